### rtl/deque_with_reverse_assert.svh
// Assertion helpers for the deque blocks.
`ifndef DEQUE_WITH_REVERSE_ASSERT_SVH
`define DEQUE_WITH_REVERSE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define DQR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque assertion failed");
// Next-cycle implication, held off during reset.
`define DQR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque assertion failed");
`else
`define DQR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DQR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/dqr_pkg.sv
`default_nettype none

package dqr_pkg;

    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_BACK   = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_TOGGLE     = 3'd4
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // At most one memory access per transaction: write for a push, read for a pop.
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_ram_req;

    // imm: result known at once (status only); rd: pop result follows from memory.
    typedef struct packed {
        logic    imm;
        logic    rd;
        t_status status;
    } t_ctl_res;

endpackage

`default_nettype wire

### rtl/dqr_cmd_if.sv
`default_nettype none

interface dqr_cmd_if import dqr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

### rtl/dqr_res_if.sv
`default_nettype none

interface dqr_res_if import dqr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] popped_value;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output popped_value, output status, input ready);
    modport sink   (input valid, input popped_value, input status, output ready);
endinterface

`default_nettype wire

### rtl/dqr_ram.sv
`default_nettype none

module dqr_ram #(
    parameter int DEPTH_P = 1024,
    parameter int WIDTH_P = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH_P)-1:0] i_addr,
    input  wire logic [WIDTH_P-1:0]         i_wdata,
    output logic      [WIDTH_P-1:0]         o_rdata
);

    logic [WIDTH_P-1:0] r_mem [DEPTH_P];
    logic [WIDTH_P-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/dqr_ctrl.sv
`default_nettype none

module dqr_ctrl import dqr_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_acc,
    input  wire logic [MODE_W-1:0]        i_mode,
    input  wire logic signed [DATA_W-1:0] i_value,
    output t_ram_req                      o_ram,
    output t_ctl_res                      o_res
);

    localparam int SUM_W = CNT_W + 1;

    logic [ADDR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_rev, n_rev;

    t_mode             w_mode;
    logic              w_full, w_empty, w_front;
    logic [ADDR_W-1:0] w_head_dec, w_head_inc, w_end_wrap, w_last_wrap;
    logic [SUM_W-1:0]  w_end, w_last;

    assign w_mode  = t_mode'(i_mode);
    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // Ring arithmetic; sums stay below twice the depth, so one subtract wraps.
    assign w_head_dec = (r_head == '0) ? ADDR_W'(DEPTH - 1) : r_head - 1'b1;
    assign w_head_inc = (r_head == ADDR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_end      = SUM_W'(r_head) + SUM_W'(r_count);
    assign w_last     = w_end - 1'b1;
    assign w_end_wrap = (w_end >= SUM_W'(DEPTH)) ? ADDR_W'(w_end - SUM_W'(DEPTH))
                                                 : ADDR_W'(w_end);
    assign w_last_wrap = (w_last >= SUM_W'(DEPTH)) ? ADDR_W'(w_last - SUM_W'(DEPTH))
                                                   : ADDR_W'(w_last);

    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_rev        = r_rev;
        w_front      = 1'b0;
        o_ram.we     = 1'b0;
        o_ram.re     = 1'b0;
        o_ram.addr   = r_head;
        o_ram.wdata  = i_value;
        o_res.imm    = 1'b0;
        o_res.rd     = 1'b0;
        o_res.status = ST_OK;
        if (i_acc) begin
            case (w_mode)
                MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
                    // reverse swaps the physical end
                    w_front = (w_mode == MODE_PUSH_FRONT) ^ r_rev;
                    if (w_full) begin
                        o_res.imm    = 1'b1;
                        o_res.status = ST_FULL;
                    end else begin
                        o_ram.we   = 1'b1;
                        o_ram.addr = w_front ? w_head_dec : w_end_wrap;
                        n_head     = w_front ? w_head_dec : r_head;
                        n_count    = r_count + 1'b1;
                    end
                end
                MODE_POP_BACK, MODE_POP_FRONT: begin
                    w_front = (w_mode == MODE_POP_FRONT) ^ r_rev;
                    if (w_empty) begin
                        o_res.imm    = 1'b1;
                        o_res.status = ST_EMPTY;
                    end else begin
                        o_ram.re   = 1'b1;
                        o_res.rd   = 1'b1;
                        o_ram.addr = w_front ? r_head : w_last_wrap;
                        n_head     = w_front ? w_head_inc : r_head;
                        n_count    = r_count - 1'b1;
                    end
                end
                MODE_TOGGLE: begin
                    n_rev = ~r_rev;
                end
                default: begin
                    // unused codes: no effect
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

endmodule

`default_nettype wire

### rtl/deque_with_reverse.sv
// Channel  Dir  Payload                      Transaction
// i_cmd    in   mode[2:0], value[31:0]       valid & ready at rising edge
// o_res    out  popped_value[31:0], status   valid & ready at rising edge
//
// Pushes, toggles and unused codes give no result; a failed (full/empty) operation's
// status is registered at once. A successful pop reads the entry memory, then its data
// is registered; input is held off while that read is in flight.
// Reset (synchronous, active low) empties the deque and clears the reverse flag;
// the entry memory is not cleared, since only written entries are read.
// A stalled result holds the input off; the next transaction enters as it leaves.

`default_nettype none

`include "deque_with_reverse_assert.svh"

module deque_with_reverse import dqr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dqr_cmd_if.sink    i_cmd,
    dqr_res_if.source  o_res
);

    t_ram_req          w_ram;
    t_ctl_res          w_ctl;
    logic              w_acc;
    logic [DATA_W-1:0] w_rdata;

    // pop read in flight; the result lands in the output register next edge
    logic              r_pend;
    logic              r_ov;
    logic [DATA_W-1:0] r_od;
    t_status           r_os;

    // No new transaction while a read is pending; otherwise accept whenever the
    // output register is free or is being drained in this cycle.
    assign i_cmd.ready = !r_pend && (!r_ov || o_res.ready);
    assign w_acc       = i_cmd.valid && i_cmd.ready;

    dqr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_mode  (i_cmd.mode),
        .i_value (i_cmd.value),
        .o_ram   (w_ram),
        .o_res   (w_ctl)
    );

    dqr_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_re    (w_ram.re),
        .i_addr  (w_ram.addr),
        .i_wdata (w_ram.wdata),
        .o_rdata (w_rdata)
    );

    // Control: valid flags. A pending read always finds the output register
    // free, since it was free or draining when the pop was taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_pend <= w_acc && w_ctl.rd;
            if (r_pend || (w_acc && w_ctl.imm)) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload: memory data for a good pop, zero with a status otherwise.
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_od <= w_rdata;
            r_os <= ST_OK;
        end else if (w_acc && w_ctl.imm) begin
            r_od <= '0;
            r_os <= w_ctl.status;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.popped_value = r_od;
    assign o_res.status       = r_os;

    // Input stays closed while a pop read is outstanding.
    `DQR_ASSERT_IMPLY(a_pend_blocks_input, i_clk, i_rst_n, r_pend, !i_cmd.ready)
    // A pop read always turns into a good result on the next cycle.
    `DQR_ASSERT_NEXT(a_pend_gives_ok, i_clk, i_rst_n, r_pend, r_ov && (r_os == ST_OK))
    // Failed operations carry a zero value.
    `DQR_ASSERT_IMPLY(a_fail_zero, i_clk, i_rst_n, r_ov && (r_os != ST_OK), r_od == '0)

endmodule

`default_nettype wire

### tb/tb_deque_with_reverse.sv
`default_nettype none

// Checks the reversible bounded deque: every accepted command updates a
// mirror of the deque, and every result leaving o_res is compared against
// the oldest outstanding prediction.
module tb_deque_with_reverse;
    import dqr_pkg::*;

    // Generous watchdog limit for the whole run.
    localparam int CYCLE_LIMIT   = 400000;
    // Cycles allowed after the last result, so that a push still in flight can settle.
    localparam int SETTLE_CYCLES = 8;

    // Codes above MODE_TOGGLE are unused and must be swallowed silently.
    localparam logic [MODE_W-1:0] MODE_CODE_MAX = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        t_status                  status;
    } t_deque_reply;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dqr_cmd_if cmd_ch ();
    dqr_res_if res_ch ();

    deque_with_reverse uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mirror of the deque: ring buffer, physical head, fill level, flag.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] mirror_store [DEPTH];
    logic [ADDR_W-1:0]        mirror_head     = '0;
    logic [CNT_W-1:0]         mirror_count    = '0;
    logic                     mirror_reversed = 1'b0;

    t_deque_reply pending_replies [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_request   = 0;

    // Applies one command to the mirror; returns 1 when the block owes a result.
    // Address arithmetic is truncated to ADDR_W, which gives the ring wrap.
    function automatic bit mirror_deque_op(input logic [MODE_W-1:0] op,
                                           input logic signed [DATA_W-1:0] val,
                                           output t_deque_reply reply);
        logic              at_front;
        logic [ADDR_W-1:0] slot;
        reply.popped_value = '0;
        reply.status       = ST_OK;
        case (op)
            MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
                if (mirror_count == CNT_W'(DEPTH)) begin
                    reply.status = ST_FULL;
                    return 1'b1;
                end
                // reverse swaps which physical end a logical end refers to
                at_front = (op == MODE_PUSH_FRONT) ^ mirror_reversed;
                if (at_front) begin
                    mirror_head = mirror_head - 1'b1;
                    slot        = mirror_head;
                end else begin
                    slot = mirror_head + mirror_count[ADDR_W-1:0];
                end
                mirror_store[slot] = val;
                mirror_count       = mirror_count + 1'b1;
                return 1'b0;
            end
            MODE_POP_BACK, MODE_POP_FRONT: begin
                if (mirror_count == '0) begin
                    reply.status = ST_EMPTY;
                    return 1'b1;
                end
                at_front = (op == MODE_POP_FRONT) ^ mirror_reversed;
                if (at_front) begin
                    reply.popped_value = mirror_store[mirror_head];
                    mirror_head        = mirror_head + 1'b1;
                end else begin
                    slot               = mirror_head + mirror_count[ADDR_W-1:0] - 1'b1;
                    reply.popped_value = mirror_store[slot];
                end
                mirror_count = mirror_count - 1'b1;
                return 1'b1;
            end
            MODE_TOGGLE: begin
                mirror_reversed = ~mirror_reversed;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Monitor: results are checked before the command of the same edge is
    // predicted, though a result never leaves on the edge its command enters.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_deque_reply want;
        t_deque_reply pred;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_replies.size() == 0) begin
                    $error("unexpected result: popped_value %0d, status %0d",
                           res_ch.popped_value, res_ch.status);
                    mismatch_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (res_ch.popped_value !== want.popped_value) begin
                        $error("popped_value: expected %0d, actual %0d",
                               want.popped_value, res_ch.popped_value);
                        mismatch_count++;
                    end
                    if (res_ch.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, res_ch.status);
                        mismatch_count++;
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                if (mirror_deque_op(cmd_ch.mode, cmd_ch.value, pred))
                    pending_replies = {pending_replies, pred};
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure, or a long hold-off on request.
    // At most one assignment to ready per edge.
    // ------------------------------------------------------------------
    initial begin
        int stall_len;
        res_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request != 0) begin
                stall_len    = hold_request;
                hold_request = 0;
                res_ch.ready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Command side.
    // ------------------------------------------------------------------

    // Offers one transaction and returns on the edge that accepts it, with
    // valid still high so that back-to-back transactions need no gap.
    task automatic issue_op(input logic [MODE_W-1:0] op,
                            input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.mode  <= MODE_W'($urandom);   // junk while idle
            cmd_ch.value <= $urandom;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.mode  <= op;
        cmd_ch.value <= val;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly pushes and pops with random ends; toggles and unused codes
    // sprinkled in. push_pct steers the fill level.
    task automatic issue_random_op(input int unsigned push_pct);
        int unsigned roll;
        logic [MODE_W-1:0] op;
        roll = $urandom_range(99);
        if (roll < 3)
            op = MODE_W'($urandom_range(MODE_CODE_MAX, MODE_TOGGLE + 1));
        else if (roll < 9)
            op = MODE_TOGGLE;
        else if ($urandom_range(99) < push_pct)
            op = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
        else
            op = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
        issue_op(op, pick_value());
    endtask

    // Sender goes quiet until every result is home, then lets a push in
    // flight finish.
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Empty pops, extremes, head wrap on a front push, both ends in both
    // directions, and the unused codes.
    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        issue_op(MODE_POP_BACK, pick_value());
        issue_op(MODE_POP_FRONT, pick_value());
        issue_op(MODE_PUSH_FRONT, VAL_MIN);          // head wraps below zero
        issue_op(MODE_PUSH_BACK, VAL_MAX);
        issue_op(MODE_PUSH_BACK, '0);
        issue_op(MODE_PUSH_FRONT, -1);
        issue_op(MODE_POP_FRONT, pick_value());
        issue_op(MODE_POP_BACK, pick_value());
        issue_op(MODE_TOGGLE, pick_value());
        issue_op(MODE_POP_FRONT, pick_value());      // reversed: physical back
        issue_op(MODE_PUSH_FRONT, 32'sh1234_5678);
        issue_op(MODE_PUSH_BACK, 32'sh5a5a_a5a5);
        issue_op(MODE_POP_BACK, pick_value());
        for (int code = MODE_TOGGLE + 1; code <= MODE_CODE_MAX; code++)
            issue_op(MODE_W'(code), $urandom);
        issue_op(MODE_TOGGLE, pick_value());
        issue_op(MODE_POP_BACK, pick_value());
        issue_op(MODE_POP_FRONT, pick_value());
        issue_op(MODE_POP_FRONT, pick_value());      // empty again
        issue_op(MODE_POP_BACK, pick_value());
        settle();
    endtask

    // Random traffic; the push bias flips every 40 transactions so the level
    // rises and falls.
    task automatic test_random(input int n_ops, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < n_ops; i++)
            issue_random_op(((i / 40) % 2) ? 30 : 70);
        settle();
    endtask

    // Top up to DEPTH from the current level, hit full at both ends in both
    // directions, then take a few off both ends.
    task automatic test_full();
        int held;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        held = mirror_count;
        for (int i = held; i < DEPTH; i++) begin
            if (i % 200 == 100)
                issue_op(MODE_TOGGLE, pick_value());
            issue_op($urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, pick_value());
        end
        issue_op(MODE_PUSH_BACK, pick_value());
        issue_op(MODE_PUSH_FRONT, pick_value());
        issue_op(MODE_TOGGLE, pick_value());
        issue_op(MODE_PUSH_BACK, pick_value());
        issue_op(MODE_PUSH_FRONT, pick_value());
        issue_op(MODE_POP_FRONT, pick_value());
        issue_op(MODE_POP_BACK, pick_value());
        issue_op(MODE_TOGGLE, pick_value());
        issue_op(MODE_POP_FRONT, pick_value());
        issue_op(MODE_POP_BACK, pick_value());
        settle();
    endtask

    // Receiver holds off for a long stretch while commands keep coming: the
    // output register fills and the block has to stall its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 150;
        for (int i = 0; i < 60; i++)
            issue_random_op(50);
        settle();
    endtask

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.mode  = MODE_PUSH_BACK;
        cmd_ch.value = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(150, 38, 87);
        test_random(150, 87, 38);
        test_full();
        test_backpressure();
        test_random(150, 0, 0);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/dqr_pkg.sv
rtl/dqr_cmd_if.sv
rtl/dqr_res_if.sv
rtl/dqr_ram.sv
rtl/dqr_ctrl.sv
rtl/deque_with_reverse.sv
tb/tb_deque_with_reverse.sv
